// ----- design/ffa_pkg.sv -----
// shared types, sizes and codes of the first-free id allocator
package ffa_pkg;

    // map geometry
    localparam int ID_SLOTS = 1024;
    localparam int ID_W     = 16;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WORDS    = (ID_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_AW  = WORD_AW + BIT_W;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 2'd1;
    localparam logic [ID_W-1:0] LOWEST_RST  = 16'd100;
    localparam logic [ID_W-1:0] HIGHEST_RST = 16'd1000;

    // operation codes
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] release_id;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] granted_id;
    } t_rsp;

    // word scanner control and result
    typedef struct packed {
        logic             is_last;
        logic [BIT_W-1:0] last_bit;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_scan_res;

endpackage

// ----- design/ffa_map_ram.sv -----
// used-bit map storage, one word per row, rows read as free until written
module ffa_map_ram import ffa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [WORD_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [WORD_AW-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]  i_wr_data,
    output logic [WORD_W-1:0]  o_rd_data
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]  r_row_vld;
    logic [WORD_W-1:0] r_rd_q;
    logic              r_rd_vld;

    // array write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q <= r_mem[i_rd_addr];
    end

    // row valid bits, cleared by reset so the map starts all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

// ----- design/ffa_scan_unit.sv -----
// find-first-free bit of one map word, bounded by the last usable slot
module ffa_scan_unit import ffa_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  t_scan_ctl         i_ctl,
    output t_scan_res         o_res
);

    logic [WORD_W-1:0] w_free;

    // free bits that lie inside the usable range
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_free[b] = !i_word[b] &&
                        (!i_ctl.is_last || (BIT_W'(b) <= i_ctl.last_bit));
        end
    end

    // lowest set bit wins
    always_comb begin
        o_res = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                o_res.found = 1'b1;
                o_res.idx   = BIT_W'(b);
            end
        end
    end

endmodule

// ----- design/first_free_id_allocator_unit.sv -----
// top level: id allocator sequencer, configuration and result register
// Bitmap id allocator. An allocate transaction returns the lowest free id in
// [lowest_id, highest_id] (capped at ID_SLOTS ids) and marks it used; a
// release transaction frees one id or reports out of range. The map sits in
// a 32-bit-wide RAM and one shared word scanner walks it one word per cycle,
// so an allocate reads the words up to the first free bit (at most 32 for
// 1024 slots); a release reads and rewrites one word, and an empty range or
// an out-of-range release skips the map. The block takes one transaction
// at a time; the result sits in an output register, so the next transaction
// is taken while an earlier result still waits. Reset frees all ids at once
// through per-row valid bits, with no clearing pass.
module first_free_id_allocator_unit import ffa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ID_W-1:0]      i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_AREAD = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RREAD = 6'b001000,
        S_RMOD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_lowest, r_highest;
    logic [WORD_AW-1:0] r_word, n_word;
    logic [WORD_AW-1:0] r_last_word, n_last_word;
    logic [BIT_W-1:0]   r_last_bit, n_last_bit;
    logic [BIT_W-1:0]   r_rel_bit, n_rel_bit;
    t_rsp               r_res, n_res;
    logic               r_o_valid;
    t_rsp               r_o_data;

    logic [WORD_AW-1:0] w_rd_addr;
    logic               w_wr_en;
    logic [WORD_W-1:0]  w_wr_data;
    logic [WORD_W-1:0]  w_rd_data;
    t_scan_ctl          w_scan_ctl;
    t_scan_res          w_scan_res;
    logic [ID_W:0]      w_diff, w_off, w_last_slot;
    logic [SLOT_AW-1:0] w_slot_last, w_off_slot, w_grant_slot;
    logic               w_empty, w_rel_ok;
    logic               w_out_free;

    ffa_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    assign w_scan_ctl.is_last  = (r_word == r_last_word);
    assign w_scan_ctl.last_bit = r_last_bit;

    ffa_scan_unit u_scan (
        .i_word (w_rd_data),
        .i_ctl  (w_scan_ctl),
        .o_res  (w_scan_res)
    );

    // scan bound and release check, taken at accept time
    assign w_empty     = (r_highest < r_lowest);
    assign w_diff      = {1'b0, r_highest} - {1'b0, r_lowest};
    assign w_last_slot = (w_diff > (ID_W+1)'(ID_SLOTS - 1)) ?
                         (ID_W+1)'(ID_SLOTS - 1) : w_diff;
    assign w_slot_last = w_last_slot[SLOT_AW-1:0];
    assign w_off       = {1'b0, i_in_data.release_id} - {1'b0, r_lowest};
    assign w_off_slot  = w_off[SLOT_AW-1:0];
    assign w_rel_ok    = (i_in_data.release_id >= r_lowest) &&
                         (i_in_data.release_id <= r_highest) &&
                         (w_off < (ID_W+1)'(ID_SLOTS));
    assign w_grant_slot = {r_word, w_scan_res.idx};
    assign w_out_free   = !r_o_valid || i_out_ready;

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_last_word = r_last_word;
        n_last_bit  = r_last_bit;
        n_rel_bit   = r_rel_bit;
        n_res       = r_res;
        w_rd_addr   = r_word;
        w_wr_en     = 1'b0;
        w_wr_data   = w_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '0;
                    if (i_in_data.kind == KIND_ALLOC) begin
                        n_word      = '0;
                        n_last_word = w_slot_last[SLOT_AW-1:BIT_W];
                        n_last_bit  = w_slot_last[BIT_W-1:0];
                        if (w_empty) begin
                            n_res.status = ST_FULL;
                            n_state      = S_OUT;
                        end else begin
                            n_state = S_AREAD;
                        end
                    end else if (w_rel_ok) begin
                        n_word    = w_off_slot[SLOT_AW-1:BIT_W];
                        n_rel_bit = w_off_slot[BIT_W-1:0];
                        n_state   = S_RREAD;
                    end else begin
                        n_res.status = ST_RANGE;
                        n_state      = S_OUT;
                    end
                end
            end
            S_AREAD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // read of the next word runs alongside the scan of this one
                w_rd_addr = WORD_AW'(r_word + 1'b1);
                if (w_scan_res.found) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_rd_data | (WORD_W'(1) << w_scan_res.idx);
                    n_res.status     = ST_OK;
                    n_res.granted_id = r_lowest + ID_W'(w_grant_slot);
                    n_state          = S_OUT;
                end else if (w_scan_ctl.is_last) begin
                    n_res.status = ST_FULL;
                    n_state      = S_OUT;
                end else begin
                    n_word = WORD_AW'(r_word + 1'b1);
                end
            end
            S_RREAD: begin
                n_state = S_RMOD;
            end
            S_RMOD: begin
                w_wr_en      = 1'b1;
                w_wr_data    = w_rd_data & ~(WORD_W'(1) << r_rel_bit);
                n_res.status = ST_OK;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_lowest  <= LOWEST_RST;
            r_highest <= HIGHEST_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == REG_LOWEST) begin
                r_lowest <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_index == REG_HIGHEST) begin
                r_highest <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_last_word <= n_last_word;
        r_last_bit  <= n_last_bit;
        r_rel_bit   <= n_rel_bit;
        r_res       <= n_res;
        if (r_state == S_OUT && w_out_free) begin
            r_o_data <= r_res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // a taken transaction drops ready until its result is queued
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a transaction was taken");

    // the scan never walks past the last usable word
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_word <= r_last_word))
        else $error("map scan ran past the usable range");

    // only a successful allocate carries an id
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.granted_id == '0))
        else $error("failed transaction returned a nonzero id");

endmodule

// ----- dv/first_free_id_allocator_unit_test.sv -----
// self-checking testbench for the first-free id allocator
`timescale 1ns / 100ps

module first_free_id_allocator_unit_test import ffa_pkg::*;;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            what;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 kind;
        logic [ID_W-1:0]      value;
        bit                   typed;
        t_rsp                 rsp;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_req                 i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_rsp                 o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ID_W-1:0]      i_cfg_wdata;

    // allocator state as the testbench sees it
    logic [ID_SLOTS-1:0] slot_used;
    logic [ID_W-1:0]     low_lim;
    logic [ID_W-1:0]     high_lim;
    t_rsp                grant_q[$];

    int unsigned mismatch_cnt = 0;
    int unsigned idle_cnt     = 0;
    int unsigned burst_left   = 0;
    int unsigned rx_tick      = 0;
    bit          hold_off_req = 1'b0;

    first_free_id_allocator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // number of slots reachable under the current limits
    function automatic int unsigned usable_count();
        int unsigned span;
        if (high_lim < low_lim) return 0;
        span = int'(high_lim) - int'(low_lim) + 1;
        return (span > ID_SLOTS) ? ID_SLOTS : span;
    endfunction

    // allocate or release against the slot map, returns the response
    function automatic t_rsp predict_response(input t_req req);
        t_rsp        rsp;
        int unsigned n;
        int unsigned off;
        rsp.status     = ST_OK;
        rsp.granted_id = '0;
        n = usable_count();
        if (req.kind == KIND_ALLOC) begin
            rsp.status = ST_FULL;
            for (int unsigned s = 0; s < n; s++) begin
                if (!slot_used[s]) begin
                    slot_used[s]   = 1'b1;
                    rsp.granted_id = ID_W'(low_lim + s);
                    rsp.status     = ST_OK;
                    break;
                end
            end
        end else if (req.release_id < low_lim || req.release_id > high_lim) begin
            rsp.status = ST_RANGE;
        end else begin
            off = req.release_id - low_lim;
            if (off >= ID_SLOTS) rsp.status = ST_RANGE;
            else slot_used[off] = 1'b0;
        end
        return rsp;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [ID_W-1:0] val);
        case (idx)
            REG_LOWEST:  low_lim  = val;
            REG_HIGHEST: high_lim = val;
            default: ;
        endcase
    endfunction

    // mostly ids that are in use, then in-range ids, then boundary and wild ids
    function automatic logic [ID_W-1:0] choose_release_id();
        int unsigned n;
        int unsigned pick;
        int unsigned start;
        int unsigned s;
        n     = usable_count();
        pick  = $urandom_range(0, 99);
        if (n > 0 && pick < 65) begin
            start = $urandom_range(0, n - 1);
            for (int unsigned k = 0; k < n; k++) begin
                s = (start + k) % n;
                if (slot_used[s]) return ID_W'(low_lim + s);
            end
            return ID_W'(low_lim + start);
        end
        if (n > 0 && pick < 75) return ID_W'(low_lim + $urandom_range(0, n - 1));
        case ($urandom_range(0, 3))
            0: return low_lim - 1'b1;
            1: return high_lim + 1'b1;
            2: return ID_W'(low_lim + ID_SLOTS);
            default: return ID_W'($urandom);
        endcase
    endfunction

    function automatic t_row req_row(input logic kind, input logic [ID_W-1:0] id);
        t_row r;
        r.what    = ROW_REQ;
        r.reg_idx = REG_LOWEST;
        r.kind    = kind;
        r.value   = id;
        r.typed   = 1'b0;
        r.rsp     = '0;
        return r;
    endfunction

    function automatic t_row chk_row(input logic kind, input logic [ID_W-1:0] id,
                                     input logic [1:0] st, input logic [ID_W-1:0] gid);
        t_row r;
        r = req_row(kind, id);
        r.typed          = 1'b1;
        r.rsp.status     = st;
        r.rsp.granted_id = gid;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [ID_W-1:0] val);
        t_row r;
        r = req_row(KIND_ALLOC, val);
        r.what    = ROW_CFG;
        r.reg_idx = idx;
        return r;
    endfunction

    // offer one transaction and hold it until taken
    task automatic put_req(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp want;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = predict_response(req);
        if (typed) want = typed_rsp;
        grant_q.push_back(want);
    endtask

    task automatic idle_for(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // bursts of random length with random gaps in between
    task automatic paced_put(input t_req req, input bit pace_on);
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
            end
            burst_left--;
        end
        put_req(req, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        apply_reg_write(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver: rotating stall pattern, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else begin
                rx_tick++;
                case ((rx_tick / 50) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= rx_tick[0];
                    2: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grant_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: status %0d id %0d",
                             o_out_data.status, o_out_data.granted_id);
            end else begin
                want = grant_q.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.granted_id !== want.granted_id) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: exp status %0d id %0d, got status %0d id %0d",
                                 want.status, want.granted_id,
                                 o_out_data.status, o_out_data.granted_id);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row            stim_rows[$];
        t_req            req;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        int unsigned     n_items;
        int unsigned     alloc_pct;
        int unsigned     span;
        bit              pace_on;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_LOWEST;
        i_cfg_wdata = '0;
        slot_used   = '0;
        low_lim     = LOWEST_RST;
        high_lim    = HIGHEST_RST;

        // reset limits 100..1000: first grants, range errors, double release
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_OK,    16'd100));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_OK,    16'd101));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd99,    ST_RANGE, 16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd1001,  ST_RANGE, 16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd0,     ST_RANGE, 16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'hFFFF,  ST_RANGE, 16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd100,   ST_OK,    16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd100,   ST_OK,    16'd0));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_OK,    16'd100));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_OK,    16'd102));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'hFFFF,  ST_OK,    16'd103));
        // top of the id space, four slots that the old bits already fill
        stim_rows.push_back(cfg_row(REG_LOWEST,  16'd65532));
        stim_rows.push_back(cfg_row(REG_HIGHEST, 16'd65535));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_FULL,  16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd65535, ST_OK,    16'd0));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_OK,    16'd65535));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_FULL,  16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd65531, ST_RANGE, 16'd0));
        stim_rows.push_back(req_row(KIND_RELEASE, 16'd65532));
        stim_rows.push_back(req_row(KIND_ALLOC,   16'd0));
        // empty range
        stim_rows.push_back(cfg_row(REG_LOWEST,  16'd5));
        stim_rows.push_back(cfg_row(REG_HIGHEST, 16'd4));
        stim_rows.push_back(chk_row(KIND_ALLOC,   16'd0,     ST_FULL,  16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd4,     ST_RANGE, 16'd0));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd5,     ST_RANGE, 16'd0));
        // full id space, capped to the map; ids past the map have no slot
        stim_rows.push_back(cfg_row(REG_LOWEST,  16'd0));
        stim_rows.push_back(cfg_row(REG_HIGHEST, 16'hFFFF));
        stim_rows.push_back(chk_row(KIND_RELEASE, 16'd1024,  ST_RANGE, 16'd0));
        stim_rows.push_back(req_row(KIND_RELEASE, 16'd1023));
        stim_rows.push_back(req_row(KIND_ALLOC,   16'd0));
        // writes to spare indexes change nothing
        stim_rows.push_back(cfg_row(REG_SPARE_B, 16'h0000));
        stim_rows.push_back(cfg_row(REG_SPARE_A, 16'hFFFF));
        stim_rows.push_back(req_row(KIND_ALLOC,   16'd0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (stim_rows[i]) begin
            if (stim_rows[i].what == ROW_CFG) begin
                wait_drained();
                program_reg(stim_rows[i].reg_idx, stim_rows[i].value);
            end else begin
                req.kind       = stim_rows[i].kind;
                req.release_id = stim_rows[i].value;
                put_req(req, stim_rows[i].typed, stim_rows[i].rsp);
            end
        end

        // random phases, each under its own limits; the map carries over
        for (int ph = 0; ph < 12; ph++) begin
            alloc_pct = 60;
            case (ph % 6)
                0: begin
                    n_items = 55;
                    if (ph < 6) begin
                        lo = LOWEST_RST;
                        hi = HIGHEST_RST;
                    end else begin
                        lo   = ID_W'($urandom);
                        span = $urandom_range(100, 1500);
                        hi   = (int'(lo) + span > 65535) ? 16'hFFFF : ID_W'(lo + span);
                    end
                end
                1: begin
                    n_items = 50;
                    case ($urandom_range(0, 5))
                        0: span = 1;
                        1: span = 2;
                        2: span = 31;
                        3: span = 32;
                        4: span = 33;
                        default: span = 40;
                    endcase
                    lo = ID_W'($urandom_range(0, 65536 - span));
                    hi = ID_W'(lo + span - 1);
                end
                2: begin
                    n_items   = 50;
                    alloc_pct = 55;
                    lo = (ph < 6) ? 16'd0 : ID_W'($urandom_range(0, 60000));
                    hi = 16'hFFFF;
                end
                3: begin
                    n_items = 10;
                    hi = ID_W'($urandom_range(0, 65534));
                    lo = ID_W'($urandom_range(hi + 1, 65535));
                end
                4: begin
                    n_items = 20;
                    lo = ID_W'($urandom);
                    hi = lo;
                end
                default: begin
                    n_items = 45;
                    span = $urandom_range(1, 40);
                    hi = 16'hFFFF;
                    lo = ID_W'(65536 - span);
                end
            endcase

            wait_drained();
            if ($urandom_range(0, 2) == 0)
                program_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                            ID_W'($urandom));
            program_reg(REG_LOWEST, lo);
            program_reg(REG_HIGHEST, hi);

            // long receiver hold-off while transactions keep coming
            pace_on = (ph % 4 != 3) && (ph != 1);
            if (ph == 1) hold_off_req = 1'b1;

            repeat (n_items) begin
                req.kind       = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_RELEASE;
                req.release_id = (req.kind == KIND_ALLOC) ? ID_W'($urandom)
                                                          : choose_release_id();
                paced_put(req, pace_on);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ffa_pkg.sv
design/ffa_map_ram.sv
design/ffa_scan_unit.sv
design/first_free_id_allocator_unit.sv
dv/first_free_id_allocator_unit_test.sv
